// ===== design/gif_lzw_decoder_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GIF_LZW_DECODER_UNIT_MACROS_SVH
`define GIF_LZW_DECODER_UNIT_MACROS_SVH
`define GLZW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GLZW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/glzw_pkg.sv =====
package glzw_pkg;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_PIXEL  = 3'd2;
    localparam logic [2:0] ST_NEED   = 3'd3;
    localparam logic [2:0] ST_END    = 3'd4;
    localparam logic [2:0] ST_ERROR  = 3'd5;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Finish states.
    typedef enum logic [1:0] {
        FIN_RUN  = 2'd0,
        FIN_TERM = 2'd1,
        FIN_DONE = 2'd2,
        FIN_ERR  = 2'd3
    } fin_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CODE  = 6'b000010,
        S_WALK  = 6'b000100,
        S_WRITE = 6'b001000,
        S_POP   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

// ===== design/gif_lzw_decoder_unit.sv =====
// LZW image data decoder that strips sub-block framing; reset (aresetn low, synchronous) or
// a min_code_size write restarts it, while the tables and the stack keep their contents.
// A push is answered from S_IDLE; a pull from a loaded stack goes through S_POP and S_OUT;
// a pull that decodes a code goes through S_CODE, which answers need, end or error itself,
// then S_WALK, S_WRITE, S_POP and S_OUT, with a literal after a clear going straight to S_POP.
// A new input is taken only after the result of the previous one has been taken.
module gif_lzw_decoder_unit #(
    parameter int MAX_CODE_BITS = 12,
    parameter int TABLE_DEPTH   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [2:0] status, [10:3] pixel, [11] string_end
    output logic        m_tuser
);
    import glzw_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    // Dictionary and string stack memories.
    logic [11:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]  suffix_mem [TABLE_DEPTH];
    logic [7:0]  stack_mem  [TABLE_DEPTH];

    logic [3:0]  min_reg, min_next;
    state_t      state_reg, state_next;
    fin_t        fin_reg, fin_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [CW-1:0] nfc_reg, nfc_next;
    logic [3:0]  cw_reg, cw_next;
    logic [11:0] prev_reg, prev_next;
    logic [7:0]  first_reg, first_next;
    logic [23:0] buf_reg, buf_next;
    logic [4:0]  bc_reg, bc_next;
    logic [7:0]  left_reg, left_next;
    logic        ac_reg, ac_next;
    logic [11:0] walk_reg, walk_next;
    logic [11:0] code_reg, code_next;
    logic        ovalid_reg, ovalid_next;
    logic [2:0]  ost_reg, ost_next;
    logic [7:0]  opix_reg, opix_next;
    logic        olast_reg, olast_next;

    logic [11:0] pre_rd;
    logic [7:0]  suf_rd, stk_rd;
    logic        tbl_we, stk_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr, stk_waddr, stk_raddr;
    logic [11:0] tbl_wpre;
    logic [7:0]  tbl_wsuf, stk_wdata;

    // Effective code size values.
    logic [3:0]  eff_min;
    logic [12:0] clear_code, end_code;
    logic [11:0] cmask;
    logic [11:0] code_w;
    logic        cfg_clr;

    // Clamps a written code size to its legal range.
    function automatic logic [3:0] eff_cfg(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < 4'd2) r = 4'd2;
        if (v > 4'd8) r = 4'd8;
        return r;
    endfunction

    always_comb begin
        priority if (min_reg < 4'd2) eff_min = 4'd2;
        else if (min_reg > 4'd8)     eff_min = 4'd8;
        else                         eff_min = min_reg;
        clear_code = 13'd1 << eff_min;
        end_code   = clear_code + 13'd1;
        cmask      = 12'((13'd1 << cw_reg) - 13'd1);
        code_w     = buf_reg[11:0] & cmask;
    end

    // Memory ports: registered reads, one write each.
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            prefix_mem[tbl_waddr] <= tbl_wpre;
            suffix_mem[tbl_waddr] <= tbl_wsuf;
        end
        pre_rd <= prefix_mem[tbl_raddr];
        suf_rd <= suffix_mem[tbl_raddr];
        if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
        stk_rd <= stack_mem[stk_raddr];
    end

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg && !cfg_we;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, olast_reg, opix_reg, ost_reg};
    assign m_tuser  = 1'b0;
    assign cfg_clr  = cfg_we;

    // Sequencer.
    always_comb begin
        logic [12:0] wnf;
        min_next = min_reg; state_next = state_reg; fin_next = fin_reg;
        sc_next = sc_reg; nfc_next = nfc_reg; cw_next = cw_reg;
        prev_next = prev_reg; first_next = first_reg; buf_next = buf_reg;
        bc_next = bc_reg; left_next = left_reg; ac_next = ac_reg;
        walk_next = walk_reg; code_next = code_reg;
        ovalid_next = ovalid_reg; ost_next = ost_reg; opix_next = opix_reg;
        olast_next = olast_reg;
        tbl_we = 1'b0; stk_we = 1'b0;
        tbl_waddr = nfc_reg[AW-1:0]; tbl_raddr = walk_reg[AW-1:0];
        tbl_wpre = prev_reg; tbl_wsuf = walk_reg[7:0];
        stk_waddr = sc_reg[AW-1:0]; stk_wdata = suf_rd;
        stk_raddr = AW'(sc_reg - CW'(1));
        wnf = 13'(nfc_reg) + 13'd1;

        if (ovalid_reg && m_tready) ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    ovalid_next = 1'b1; opix_next = 8'd0; olast_next = 1'b0;
                    ost_next = ST_ACCEPT;
                    if (fin_reg == FIN_ERR) ost_next = ST_ERROR;
                    else if (s_tuser == OP_PUSH) begin
                        if (fin_reg == FIN_RUN) begin
                            if (left_reg == 8'd0) begin
                                if (s_tdata == 8'd0) fin_next = FIN_TERM;
                                else left_next = s_tdata;
                            end else if (bc_reg > 5'd16) begin
                                ost_next = ST_FULL;
                            end else begin
                                buf_next = buf_reg | (24'(s_tdata) << bc_reg);
                                bc_next = bc_reg + 5'd8;
                                left_next = left_reg - 8'd1;
                            end
                        end
                    end else if (fin_reg == FIN_DONE) begin
                        ost_next = ST_END;
                    end else if (sc_reg != '0) begin
                        ovalid_next = 1'b0;
                        state_next = S_POP;
                    end else begin
                        ovalid_next = 1'b0;
                        state_next = S_CODE;
                    end
                end
            end
            S_CODE: begin
                ovalid_next = 1'b1; opix_next = 8'd0; olast_next = 1'b0;
                state_next = S_IDLE;
                if ({1'b0, bc_reg} < {1'b0, cw_reg}) begin
                    if (fin_reg == FIN_TERM) begin
                        ost_next = ST_ERROR; fin_next = FIN_ERR;
                    end else ost_next = ST_NEED;
                end else begin
                    buf_next = buf_reg >> cw_reg;
                    bc_next = bc_reg - 5'(cw_reg);
                    code_next = code_w;
                    if (13'(code_w) == end_code) begin
                        fin_next = FIN_DONE; ost_next = ST_END;
                    end else if (13'(code_w) == clear_code) begin
                        cw_next = eff_min + 4'd1;
                        nfc_next = CW'(end_code + 13'd1);
                        ac_next = 1'b1;
                        ovalid_next = 1'b0;
                        state_next = S_CODE;
                    end else if (ac_reg) begin
                        if (13'(code_w) > clear_code) begin
                            ost_next = ST_ERROR; fin_next = FIN_ERR;
                        end else begin
                            stk_we = 1'b1; stk_wdata = code_w[7:0];
                            sc_next = sc_reg + CW'(1);
                            prev_next = code_w; first_next = code_w[7:0];
                            ac_next = 1'b0;
                            ovalid_next = 1'b0; state_next = S_POP;
                        end
                    end else if (13'(code_w) > 13'(nfc_reg)) begin
                        ost_next = ST_ERROR; fin_next = FIN_ERR;
                    end else if (13'(code_w) == 13'(nfc_reg)) begin
                        stk_we = 1'b1; stk_wdata = first_reg;
                        sc_next = sc_reg + CW'(1);
                        walk_next = prev_reg; tbl_raddr = prev_reg[AW-1:0];
                        ovalid_next = 1'b0; state_next = S_WALK;
                    end else if (32'(code_w) >= TABLE_DEPTH) begin
                        ost_next = ST_ERROR; fin_next = FIN_ERR;
                    end else begin
                        walk_next = code_w; tbl_raddr = code_w[AW-1:0];
                        ovalid_next = 1'b0; state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Table data for walk_reg is present on the read port.
                if (13'(walk_reg) > end_code && 32'(walk_reg) < TABLE_DEPTH
                        && 32'(sc_reg) < TABLE_DEPTH) begin
                    stk_we = 1'b1; stk_wdata = suf_rd;
                    sc_next = sc_reg + CW'(1);
                    walk_next = pre_rd; tbl_raddr = pre_rd[AW-1:0];
                end else begin
                    walk_next = {4'd0, walk_reg[7:0]};
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (32'(sc_reg) < TABLE_DEPTH) begin
                    stk_we = 1'b1; stk_wdata = walk_reg[7:0];
                    sc_next = sc_reg + CW'(1);
                end
                first_next = walk_reg[7:0];
                if (32'(nfc_reg) < TABLE_DEPTH) begin
                    tbl_we = 1'b1;
                    nfc_next = CW'(wnf);
                    if (wnf >= (13'd1 << cw_reg) && 32'(cw_reg) < MAX_CODE_BITS)
                        cw_next = cw_reg + 4'd1;
                end
                prev_next = code_reg;
                state_next = S_POP;
            end
            S_POP: begin
                if (sc_reg == '0) begin
                    ovalid_next = 1'b1; ost_next = ST_ERROR; fin_next = FIN_ERR;
                    opix_next = 8'd0; olast_next = 1'b0;
                    state_next = S_IDLE;
                end else begin
                    sc_next = sc_reg - CW'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                ovalid_next = 1'b1; ost_next = ST_PIXEL;
                opix_next = stk_rd; olast_next = (sc_reg == '0);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_clr) begin
            min_next = cfg_wdata;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clr) begin
            min_reg <= aresetn ? min_next : 4'd8;
            state_reg <= S_IDLE; fin_reg <= FIN_RUN; sc_reg <= '0;
            nfc_reg <= CW'(((13'd1 << (aresetn ? eff_cfg(cfg_wdata) : 4'd8))) + 13'd2);
            cw_reg <= (aresetn ? eff_cfg(cfg_wdata) : 4'd8) + 4'd1;
            prev_reg <= '0; first_reg <= '0; buf_reg <= '0; bc_reg <= '0;
            left_reg <= '0; ac_reg <= 1'b0; ovalid_reg <= 1'b0;
        end else begin
            min_reg <= min_next; state_reg <= state_next; fin_reg <= fin_next;
            sc_reg <= sc_next; nfc_reg <= nfc_next; cw_reg <= cw_next;
            prev_reg <= prev_next; first_reg <= first_next; buf_reg <= buf_next;
            bc_reg <= bc_next; left_reg <= left_next; ac_reg <= ac_next;
            ovalid_reg <= ovalid_next;
        end
        walk_reg <= walk_next; code_reg <= code_next;
        ost_reg <= ost_next; opix_reg <= opix_next; olast_reg <= olast_next;
    end

endmodule

// ===== design/glzw_checker.sv =====
`include "gif_lzw_decoder_unit_macros.svh"
module glzw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import glzw_pkg::*;

    // A held result keeps its data.
    `GLZW_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    // A status code never leaves its legal range.
    `GLZW_ASSERT(a_status, aclk, aresetn, m_tvalid |-> m_tdata[2:0] <= ST_ERROR, "illegal status")
    // Only pixels carry string_end.
    `GLZW_ASSERT(a_last, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_PIXEL |-> !m_tdata[11], "string_end without pixel")
    // No new item is taken while a result waits.
    `GLZW_ASSERT(a_one, aclk, aresetn, m_tvalid |-> !s_tready, "input taken with result pending")
    // Reset empties the output.
    `GLZW_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule

bind gif_lzw_decoder_unit glzw_checker u_glzw_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import glzw_pkg::*;

    localparam int DICT_DEPTH  = 4096;
    localparam int WIDTH_LIMIT = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel;
        logic       string_end;
    } pixel_result_t;

    // One row of the directed table: optional register write first, then one item.
    typedef struct {
        int         cfg_value;
        logic       op;
        logic [7:0] data;
        bit         typed;
        logic [2:0] status;
        logic [7:0] pixel;
        logic       string_end;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [2:0] status, [10:3] pixel, [11] string_end
    logic        m_tuser;

    gif_lzw_decoder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Decoder state mirrored by the predictor.
    logic [11:0]  dict_prefix [DICT_DEPTH];
    logic [7:0]   dict_suffix [DICT_DEPTH];
    logic [7:0]   pix_stack [DICT_DEPTH];
    int unsigned  pix_count, free_code, cur_width, prev_code, head_char;
    int unsigned  bitbuf, bitcnt, blk_left;
    bit           just_cleared;
    fin_t         fin;
    logic [3:0]   code_size_reg = 4'd8;

    pixel_result_t expected_results[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  n_items = 0, n_pixels = 0, n_ends = 0, n_errors = 0, n_full = 0, n_phases = 0;

    function automatic int unsigned code_size_eff();
        if (code_size_reg < 2) return 2;
        if (code_size_reg > 8) return 8;
        return code_size_reg;
    endfunction

    function automatic void decoder_restart();
        pix_count    = 0;
        free_code    = (1 << code_size_eff()) + 2;
        cur_width    = code_size_eff() + 1;
        prev_code    = 0;
        head_char    = 0;
        bitbuf       = 0;
        bitcnt       = 0;
        blk_left     = 0;
        just_cleared = 1'b0;
        fin          = FIN_RUN;
    endfunction

    function automatic void stack_char(int unsigned v);
        if (pix_count < DICT_DEPTH) begin
            pix_stack[pix_count] = v[7:0];
            pix_count++;
        end
    endfunction

    // Takes codes from the bit buffer until a string sits on the stack, bits run out, or an end or error occurs.
    function automatic logic [2:0] decode_code();
        int unsigned clr, eoi, code, walk;
        clr = 1 << code_size_eff();
        eoi = clr + 1;
        while (1) begin
            if (bitcnt < cur_width) return (fin == FIN_TERM) ? ST_ERROR : ST_NEED;
            code   = bitbuf & ((1 << cur_width) - 1);
            bitbuf = (bitbuf >> cur_width) & 24'hFFFFFF;
            bitcnt = bitcnt - cur_width;
            if (code == eoi) begin
                fin = FIN_DONE;
                return ST_END;
            end
            if (code == clr) begin
                cur_width    = code_size_eff() + 1;
                free_code    = eoi + 1;
                just_cleared = 1'b1;
                continue;
            end
            if (just_cleared) begin
                if (code > clr) return ST_ERROR;
                stack_char(code);
                prev_code    = code;
                head_char    = code;
                just_cleared = 1'b0;
                return ST_PIXEL;
            end
            if (code > free_code) return ST_ERROR;
            if (code == free_code) begin
                stack_char(head_char);
                walk = prev_code;
            end else begin
                if (code >= DICT_DEPTH) return ST_ERROR;
                walk = code;
            end
            while (walk > eoi && walk < DICT_DEPTH && pix_count < DICT_DEPTH) begin
                stack_char(dict_suffix[walk]);
                walk = dict_prefix[walk];
            end
            walk = walk & 8'hFF;
            stack_char(walk);
            head_char = walk;
            if (free_code < DICT_DEPTH) begin
                dict_prefix[free_code] = prev_code[11:0];
                dict_suffix[free_code] = walk[7:0];
                free_code++;
                if (free_code >= (1 << cur_width) && cur_width < WIDTH_LIMIT) cur_width++;
            end
            prev_code = code & 12'hFFF;
            return ST_PIXEL;
        end
    endfunction

    function automatic pixel_result_t decode_item(logic op, logic [7:0] data);
        pixel_result_t r;
        logic [2:0] st;
        r = '{status: ST_ACCEPT, pixel: 8'd0, string_end: 1'b0};
        if (fin == FIN_ERR) begin
            r.status = ST_ERROR;
            return r;
        end
        if (op == OP_PUSH) begin
            if (fin != FIN_RUN) return r;
            if (blk_left == 0) begin
                if (data == 8'd0) fin = FIN_TERM;
                else blk_left = data;
                return r;
            end
            if (bitcnt > 16) begin
                r.status = ST_FULL;
                return r;
            end
            bitbuf = (bitbuf | (int'(data) << bitcnt)) & 24'hFFFFFF;
            bitcnt += 8;
            blk_left--;
            return r;
        end
        if (fin == FIN_DONE) begin
            r.status = ST_END;
            return r;
        end
        if (pix_count == 0) begin
            st = decode_code();
            if (st == ST_ERROR || (st == ST_PIXEL && pix_count == 0)) begin
                fin = FIN_ERR;
                r.status = ST_ERROR;
                return r;
            end
            if (st != ST_PIXEL) begin
                r.status = st;
                return r;
            end
        end
        pix_count--;
        r.status     = ST_PIXEL;
        r.pixel      = pix_stack[pix_count];
        r.string_end = (pix_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, pixel_result_t got, pixel_result_t want);
        $display("ERROR %0t: %s got status %0d pixel %0d end %0b, expected %0d %0d %0b",
                 $realtime, what, got.status, got.pixel, got.string_end,
                 want.status, want.pixel, want.string_end);
        mismatches++;
    endtask

    // Offers one item, waits for its transaction and queues the expected result.
    task automatic send_item(logic op, logic [7:0] data, bit typed, pixel_result_t typed_res,
                             output logic [2:0] status);
        pixel_result_t r;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        r = decode_item(op, data);
        if (typed) r = typed_res;
        expected_results.push_back(r);
        status = r.status;
        n_items++;
        case (r.status)
            ST_PIXEL: n_pixels++;
            ST_END:   n_ends++;
            ST_ERROR: n_errors++;
            ST_FULL:  n_full++;
            default: ;
        endcase
    endtask

    // Waits for the block to drain, then writes the code size register.
    task automatic write_code_size(logic [3:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        code_size_reg = value;
        decoder_restart();
    endtask

    // Builds one framed image: random valid codes, LSB-first packing, random sub-blocks.
    task automatic build_image(int n_codes, ref logic [7:0] stream[$]);
        int unsigned m, clr, eoi, gnext, gwidth, code, nbits, blen;
        longint unsigned acc;
        bit gcleared;
        logic [7:0] packed_bytes[$];
        m = code_size_eff();
        clr = 1 << m;
        eoi = clr + 1;
        gnext = eoi + 1;
        gwidth = m + 1;
        gcleared = 1'b0;
        acc = 0;
        nbits = 0;
        for (int i = 0; i <= n_codes; i++) begin
            if (i == n_codes) code = eoi;
            else if (i == 0 && $urandom_range(0, 4) != 0) code = clr;
            else if (gcleared) code = $urandom_range(0, clr - 1);
            else begin
                case ($urandom_range(0, 9))
                    0: code = clr;
                    1, 2, 3: code = $urandom_range(0, clr - 1);
                    4: code = (gnext < DICT_DEPTH) ? gnext : $urandom_range(0, clr - 1);
                    default: code = (gnext > eoi + 1) ? $urandom_range(eoi + 1, gnext - 1)
                                                      : $urandom_range(0, clr - 1);
                endcase
            end
            acc |= longint'(code) << nbits;
            nbits += gwidth;
            while (nbits >= 8) begin
                packed_bytes.push_back(acc[7:0]);
                acc >>= 8;
                nbits -= 8;
            end
            if (code == clr) begin
                gwidth = m + 1;
                gnext = eoi + 1;
                gcleared = 1'b1;
            end else if (gcleared) begin
                gcleared = 1'b0;
            end else if (code != eoi && gnext < DICT_DEPTH) begin
                gnext++;
                if (gnext >= (1 << gwidth) && gwidth < WIDTH_LIMIT) gwidth++;
            end
        end
        if (nbits > 0) packed_bytes.push_back(acc[7:0]);
        while (packed_bytes.size() > 0) begin
            blen = $urandom_range(1, 12);
            if (blen > packed_bytes.size()) blen = packed_bytes.size();
            stream.push_back(blen[7:0]);
            repeat (blen) stream.push_back(packed_bytes.pop_front());
        end
        stream.push_back(8'd0);
    endtask

    // Compares each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        pixel_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{status: m_tdata[2:0], pixel: m_tdata[10:3], string_end: m_tdata[11]};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", got, got);
            end else if (got != expected_results[0]) begin
                report_mismatch("result", got, expected_results.pop_front());
            end else begin
                void'(expected_results.pop_front());
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles", STALL_LIMIT);
            $display("gif_lzw_decoder_unit: mismatch");
            $finish;
        end
    end

    directed_row_t directed[] = '{
        // After reset: nothing buffered.
        '{-1, OP_PULL, 8'h00, 1, ST_NEED,   8'd0, 1'b0},
        // Fill the bit buffer until a data byte is refused.
        '{-1, OP_PUSH, 8'h04, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'hFF, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'hFF, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'hFF, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h00, 1, ST_FULL,   8'd0, 1'b0},
        // Code 511 is far above the next free code.
        '{-1, OP_PULL, 8'h00, 1, ST_ERROR,  8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h11, 1, ST_ERROR,  8'd0, 1'b0},
        // Empty sub-block, then a pull that runs out of bits.
        '{ 2, OP_PUSH, 8'h00, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h37, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PULL, 8'h00, 1, ST_ERROR,  8'd0, 1'b0},
        // Clear, literal 1, end at code size 2.
        '{ 2, OP_PUSH, 8'h02, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h4C, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h01, 1, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PULL, 8'h00, 1, ST_PIXEL,  8'd1, 1'b1},
        '{-1, OP_PULL, 8'h00, 1, ST_END,    8'd0, 1'b0},
        '{-1, OP_PULL, 8'h00, 1, ST_END,    8'd0, 1'b0},
        '{-1, OP_PUSH, 8'hA5, 1, ST_ACCEPT, 8'd0, 1'b0},
        // Out-of-range code sizes, first code without a clear, a clear with too few bits after it.
        '{ 0, OP_PUSH, 8'h01, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h2F, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PULL, 8'h00, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{15, OP_PUSH, 8'h02, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'h00, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PUSH, 8'hFF, 0, ST_ACCEPT, 8'd0, 1'b0},
        '{-1, OP_PULL, 8'h00, 0, ST_ACCEPT, 8'd0, 1'b0}
    };

    // Stimulus: reset, directed table, then random image phases.
    initial begin
        logic [2:0] st;
        logic [7:0] stream[$];
        logic [3:0] sizes[] = '{4'd2, 4'd8, 4'd1, 4'd9, 4'd3, 4'd5, 4'd0, 4'd15, 4'd7, 4'd4, 4'd6};
        pixel_result_t none;
        bit done;
        int guard;

        none = '{status: ST_ACCEPT, pixel: 8'd0, string_end: 1'b0};
        ref_init: begin
            code_size_reg = 4'd8;
            decoder_restart();
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].cfg_value >= 0) write_code_size(directed[i].cfg_value[3:0]);
            send_item(directed[i].op, directed[i].data, directed[i].typed,
                      '{status: directed[i].status, pixel: directed[i].pixel,
                        string_end: directed[i].string_end}, st);
        end

        while (n_items < 700) begin
            if (n_items > 620) quiet = 1'b1;
            if (n_phases == 3) hold_req = 1'b1;
            if (n_phases == 5) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (expected_results.size() == 0);
            end
            write_code_size($urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15))
                                                     : sizes[n_phases % sizes.size()]);
            n_phases++;
            stream.delete();
            if ($urandom_range(0, 9) == 0) begin
                // Noise: random operations and bytes.
                repeat ($urandom_range(10, 30))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0, none, st);
                continue;
            end
            build_image($urandom_range(0, 5) == 0 ? $urandom_range(40, 120)
                                                  : $urandom_range(3, 30), stream);
            if ($urandom_range(0, 7) == 0)
                stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
            done = 1'b0;
            guard = 0;
            while (!done && guard < 200) begin
                guard++;
                if (stream.size() > 0 && $urandom_range(0, 1) == 0) begin
                    send_item(OP_PUSH, stream[0], 0, none, st);
                    if (st != ST_FULL) void'(stream.pop_front());
                end else begin
                    send_item(OP_PULL, 8'($urandom_range(0, 255)), 0, none, st);
                    if (st == ST_ERROR || (st == ST_END && stream.size() == 0)) done = 1'b1;
                    if (st == ST_NEED && stream.size() == 0) done = 1'b1;
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Covered %0d items in %0d phases: %0d pixels, %0d end codes,",
                 n_items, n_phases, n_pixels, n_ends);
        $display("%0d error answers and %0d refused bytes.", n_errors, n_full);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("gif_lzw_decoder_unit: match");
        end else begin
            $display("gif_lzw_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/glzw_pkg.sv
design/gif_lzw_decoder_unit.sv
design/glzw_checker.sv
sim/testbench.sv
